// ----- rtl/core/bps_pkg.sv -----
// shared types, constants and tables of the blinn-phong shader
package bps_pkg;

	localparam int FRAC_BITS_DEF = 15;
	localparam int LOG_FRAC = 24;
	localparam int HH_W = 34;
	localparam int LEN_W = 17;
	localparam int DN_W = 34;
	localparam logic [15:0] SHININESS_RST = 16'd256;

	typedef enum logic [2:0] {
		REG_DIFFUSE_RED = 3'd0,
		REG_DIFFUSE_GREEN = 3'd1,
		REG_DIFFUSE_BLUE = 3'd2,
		REG_SPECULAR_RED = 3'd3,
		REG_SPECULAR_GREEN = 3'd4,
		REG_SPECULAR_BLUE = 3'd5,
		REG_SHININESS = 3'd6
	} bps_reg_t;

	typedef struct packed {
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] view_dir_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] light_dir_x;
		logic signed [15:0] light_dir_y;
		logic signed [15:0] light_dir_z;
		logic [15:0] light_red;
		logic [15:0] light_green;
		logic [15:0] light_blue;
	} bps_sample_t;

	typedef struct packed {
		logic [15:0] shade_red;
		logic [15:0] shade_green;
		logic [15:0] shade_blue;
	} bps_shade_t;

	typedef struct packed {
		logic [15:0] light_red;
		logic [15:0] light_green;
		logic [15:0] light_blue;
		logic spec_on;
	} bps_side_t;

	typedef struct packed {
		logic [15:0] diffuse_red;
		logic [15:0] diffuse_green;
		logic [15:0] diffuse_blue;
		logic [15:0] specular_red;
		logic [15:0] specular_green;
		logic [15:0] specular_blue;
		logic [15:0] shininess;
	} bps_cfg_t;

	// 2^(-2^-i) in q1.31 for i = 1..LOG_FRAC, entry i at bits [32*(i-1) +: 32]
	function automatic logic [LOG_FRAC*32-1:0] exp_tab_all();
		logic [LOG_FRAC*32-1:0] tabs;
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b_val;
		tabs = '0;
		r = 64'd1 << 30;
		for (int i = 1; i <= LOG_FRAC; i++) begin
			v = r << 31;
			res = '0;
			b_val = 64'd1 << 62;
			for (int j = 0; j < 32; j++) begin
				if (v >= res + b_val) begin
					v = v - (res + b_val);
					res = (res >> 1) + b_val;
				end else begin
					res = res >> 1;
				end
				b_val = b_val >> 2;
			end
			r = res;
			tabs[32*(i-1) +: 32] = r[31:0];
		end
		return tabs;
	endfunction

endpackage

// ----- rtl/core/bps_front.sv -----
// half vector and dot products, two stages
module bps_front #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input bps_pkg::bps_sample_t sample,
	output logic out_valid,
	output logic [bps_pkg::HH_W-1:0] hh,
	output logic [bps_pkg::DN_W-1:0] dpos,
	output logic [31-FRAC_BITS:0] ndl,
	output bps_pkg::bps_side_t side
);
	import bps_pkg::*;

	logic signed [15:0] n [3];
	logic signed [15:0] l [3];
	logic signed [15:0] v [3];
	logic signed [16:0] h [3];

	logic vld_s1, vld_s2;
	logic signed [31:0] nl_s1 [3];
	logic signed [32:0] nh_s1 [3];
	logic [32:0] hsq_s1 [3];
	bps_side_t side_s1;

	logic signed [33:0] dnl;
	logic signed [34:0] dnh;
	logic [HH_W-1:0] hh_sum;

	logic [HH_W-1:0] hh_s2;
	logic [DN_W-1:0] dpos_s2;
	logic [31-FRAC_BITS:0] ndl_s2;
	bps_side_t side_s2;

	always_comb begin
		n[0] = sample.normal_x;
		n[1] = sample.normal_y;
		n[2] = sample.normal_z;
		l[0] = sample.light_dir_x;
		l[1] = sample.light_dir_y;
		l[2] = sample.light_dir_z;
		v[0] = sample.view_dir_x;
		v[1] = sample.view_dir_y;
		v[2] = sample.view_dir_z;
		for (int c = 0; c < 3; c++) begin
			h[c] = 17'(l[c]) - 17'(v[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: per-axis products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				nl_s1[c] <= 32'(n[c]) * 32'(l[c]);
				nh_s1[c] <= 33'(n[c]) * 33'(h[c]);
				hsq_s1[c] <= 33'(34'(h[c]) * 34'(h[c]));
			end
			side_s1.light_red <= sample.light_red;
			side_s1.light_green <= sample.light_green;
			side_s1.light_blue <= sample.light_blue;
			side_s1.spec_on <= 1'b0;
		end
	end

	always_comb begin
		dnl = 34'(nl_s1[0]) + 34'(nl_s1[1]) + 34'(nl_s1[2]);
		dnh = 35'(nh_s1[0]) + 35'(nh_s1[1]) + 35'(nh_s1[2]);
		hh_sum = HH_W'(hsq_s1[0]) + HH_W'(hsq_s1[1]) + HH_W'(hsq_s1[2]);
	end

	// stage 2: sums, clamp of n.l and n.h, zero half vector flag
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s2 <= hh_sum;
			dpos_s2 <= (dnh > 35'sd0) ? dnh[DN_W-1:0] : '0;
			ndl_s2 <= (dnl > 34'sd0) ? dnl[31:FRAC_BITS] : '0;
			side_s2.light_red <= side_s1.light_red;
			side_s2.light_green <= side_s1.light_green;
			side_s2.light_blue <= side_s1.light_blue;
			side_s2.spec_on <= (hh_sum != '0);
		end
	end

	assign out_valid = vld_s2;
	assign hh = hh_s2;
	assign dpos = dpos_s2;
	assign ndl = ndl_s2;
	assign side = side_s2;

endmodule

// ----- rtl/core/bps_sqrt.sv -----
// pipelined floor square root of the squared half vector length, one result bit per stage
module bps_sqrt #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [bps_pkg::HH_W-1:0] hh,
	input logic [bps_pkg::DN_W-1:0] dpos,
	input logic [31-FRAC_BITS:0] ndl,
	input bps_pkg::bps_side_t side,
	output logic out_valid,
	output logic [bps_pkg::LEN_W-1:0] len,
	output logic [bps_pkg::DN_W-1:0] dpos_out,
	output logic [31-FRAC_BITS:0] ndl_out,
	output bps_pkg::bps_side_t side_out
);
	import bps_pkg::*;

	localparam int S = LEN_W;
	localparam int RMW = LEN_W + 2;
	localparam int NW = 32 - FRAC_BITS;

	typedef struct packed {
		logic [LEN_W-1:0] root;
		logic [RMW-1:0] rem;
		logic [HH_W-1:0] hh;
		logic [DN_W-1:0] dpos;
		logic [NW-1:0] ndl;
		bps_side_t side;
	} sq_t;

	sq_t pl_c [0:S-1];
	sq_t pl_n [0:S-1];
	sq_t pl_s [1:S];
	logic [S:1] vld_s;
	logic [RMW+1:0] remx;
	logic [RMW-1:0] trial;

	always_comb begin
		pl_c[0].root = '0;
		pl_c[0].rem = '0;
		pl_c[0].hh = hh;
		pl_c[0].dpos = dpos;
		pl_c[0].ndl = ndl;
		pl_c[0].side = side;
		for (int k = 1; k < S; k++) begin
			pl_c[k] = pl_s[k];
		end
	end

	always_comb begin
		remx = '0;
		trial = '0;
		for (int k = 0; k < S; k++) begin
			pl_n[k] = pl_c[k];
			remx = {pl_c[k].rem, pl_c[k].hh[2*(S-1-k) +: 2]};
			trial = {pl_c[k].root, 2'b01};
			if (remx >= (RMW+2)'(trial)) begin
				pl_n[k].rem = RMW'(remx - (RMW+2)'(trial));
				pl_n[k].root = {pl_c[k].root[LEN_W-2:0], 1'b1};
			end else begin
				pl_n[k].rem = remx[RMW-1:0];
				pl_n[k].root = {pl_c[k].root[LEN_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[S-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < S; k++) begin
				pl_s[k+1] <= pl_n[k];
			end
		end
	end

	assign out_valid = vld_s[S];
	assign len = pl_s[S].root;
	assign dpos_out = pl_s[S].dpos;
	assign ndl_out = pl_s[S].ndl;
	assign side_out = pl_s[S].side;

`ifndef ASSERT_OFF
	// a nonzero half vector always has a root of at least one
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_out.spec_on |-> len != '0)
		else $error("zero length for a nonzero half vector");
`endif

endmodule

// ----- rtl/core/bps_div.sv -----
// pipelined restoring divide of n.h by the half vector length, a saturation stage then one quotient bit per stage
module bps_div #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [bps_pkg::LEN_W-1:0] len,
	input logic [bps_pkg::DN_W-1:0] dpos,
	input logic [31-FRAC_BITS:0] ndl,
	input bps_pkg::bps_side_t side,
	output logic out_valid,
	output logic [FRAC_BITS:0] quot,
	output logic sat,
	output logic [31-FRAC_BITS:0] ndl_out,
	output bps_pkg::bps_side_t side_out
);
	import bps_pkg::*;

	localparam int QB = FRAC_BITS + 1;
	localparam int RW = LEN_W + QB;
	localparam int CW = DN_W + QB;
	localparam int N = QB + 1;
	localparam int NW = 32 - FRAC_BITS;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [DN_W-1:0] dpos;
		logic [RW-1:0] rem;
		logic [QB-1:0] q;
		logic sat;
		logic [NW-1:0] ndl;
		bps_side_t side;
	} dv_t;

	dv_t pl_c [0:N-1];
	dv_t pl_n [0:N-1];
	dv_t pl_s [1:N];
	logic [N:1] vld_s;
	logic [RW-1:0] dv;

	always_comb begin
		pl_c[0].len = len;
		pl_c[0].dpos = dpos;
		pl_c[0].rem = '0;
		pl_c[0].q = '0;
		pl_c[0].sat = 1'b0;
		pl_c[0].ndl = ndl;
		pl_c[0].side = side;
		for (int k = 1; k < N; k++) begin
			pl_c[k] = pl_s[k];
		end
	end

	always_comb begin
		dv = '0;
		for (int k = 0; k < N; k++) begin
			pl_n[k] = pl_c[k];
			if (k == 0) begin
				// quotient past the range of the clamp
				pl_n[k].sat = CW'(pl_c[k].dpos) >= CW'({pl_c[k].len, {QB{1'b0}}});
				pl_n[k].rem = RW'(pl_c[k].dpos);
			end else begin
				dv = RW'(pl_c[k].len) << (QB - k);
				if (pl_c[k].rem >= dv) begin
					pl_n[k].rem = pl_c[k].rem - dv;
					pl_n[k].q = {pl_c[k].q[QB-2:0], 1'b1};
				end else begin
					pl_n[k].q = {pl_c[k].q[QB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				pl_s[k+1] <= pl_n[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quot = pl_s[N].q;
	assign sat = pl_s[N].sat;
	assign ndl_out = pl_s[N].ndl;
	assign side_out = pl_s[N].side;

endmodule

// ----- rtl/core/bps_pow.sv -----
// pipelined power: log2 by repeated squaring, scale by shininess, table exponential
module bps_pow #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [FRAC_BITS:0] quot,
	input logic sat,
	input logic [15:0] expo,
	input logic [31-FRAC_BITS:0] ndl,
	input bps_pkg::bps_side_t side,
	output logic out_valid,
	output logic [FRAC_BITS:0] pw,
	output logic [31-FRAC_BITS:0] ndl_out,
	output bps_pkg::bps_side_t side_out
);
	import bps_pkg::*;

	localparam int BW = FRAC_BITS + 1;
	localparam int PW = $clog2(FRAC_BITS + 1);
	localparam int NW = 32 - FRAC_BITS;
	localparam int T_STG = LOG_FRAC + 1;
	localparam int F_STG = 2 * LOG_FRAC + 2;
	localparam int N = F_STG + 1;
	localparam logic [BW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [LOG_FRAC*32-1:0] EXP_TABS = exp_tab_all();

	typedef struct packed {
		logic [31:0] m;
		logic [LOG_FRAC-1:0] frac;
		logic [PW-1:0] hi;
		logic ov;
		logic [BW-1:0] ovv;
		logic [LOG_FRAC-1:0] f;
		logic kz;
		logic [PW-1:0] k;
		logic [31:0] acc;
		logic [BW-1:0] res;
		logic [NW-1:0] ndl;
		bps_side_t side;
	} pw_t;

	pw_t pl_c [0:N-1];
	pw_t pl_n [0:N-1];
	pw_t pl_s [1:N];
	logic [N:1] vld_s;

	logic [BW-1:0] cosv;
	logic [PW-1:0] pidx;
	logic [63:0] sq;
	logic [PW+23:0] nlog;
	logic [PW+39:0] tprod;
	logic [PW+7:0] kk;
	logic [63:0] prod;
	logic [5:0] sh;

	always_comb begin
		pl_c[0] = '0;
		pl_c[0].ndl = ndl;
		pl_c[0].side = side;
		for (int k = 1; k < N; k++) begin
			pl_c[k] = pl_s[k];
		end
	end

	always_comb begin
		cosv = '0;
		pidx = '0;
		sq = '0;
		nlog = '0;
		tprod = '0;
		kk = '0;
		prod = '0;
		sh = '0;
		for (int k = 0; k < N; k++) begin
			pl_n[k] = pl_c[k];
			if (k == 0) begin
				// clamp n.h to one, pick the early-out cases, normalize the base
				cosv = (sat || quot > ONE) ? ONE : quot;
				pl_n[k].ov = 1'b0;
				pl_n[k].ovv = '0;
				if (expo == '0) begin
					pl_n[k].ov = 1'b1;
					pl_n[k].ovv = ONE;
				end else if (cosv == '0) begin
					pl_n[k].ov = 1'b1;
				end else if (cosv >= ONE) begin
					pl_n[k].ov = 1'b1;
					pl_n[k].ovv = ONE;
				end
				pidx = '0;
				for (int b = 0; b < FRAC_BITS; b++) begin
					if (cosv[b]) begin
						pidx = PW'(b);
					end
				end
				pl_n[k].m = 32'(cosv[FRAC_BITS-1:0]) << (5'd31 - 5'(pidx));
				pl_n[k].hi = PW'(FRAC_BITS) - pidx;
				pl_n[k].frac = '0;
			end else if (k <= LOG_FRAC) begin
				// one log2 fraction bit per squaring
				sq = 64'(pl_c[k].m) * 64'(pl_c[k].m);
				if (sq[63]) begin
					pl_n[k].m = sq[63:32];
					pl_n[k].frac = {pl_c[k].frac[LOG_FRAC-2:0], 1'b1};
				end else begin
					pl_n[k].m = sq[62:31];
					pl_n[k].frac = {pl_c[k].frac[LOG_FRAC-2:0], 1'b0};
				end
			end else if (k == T_STG) begin
				// negated log times exponent, split into integer and fraction
				nlog = {pl_c[k].hi, {LOG_FRAC{1'b0}}} - (PW+24)'(pl_c[k].frac);
				tprod = (PW+40)'(nlog) * (PW+40)'(expo);
				kk = tprod[PW+39:32];
				pl_n[k].f = tprod[31:8];
				pl_n[k].kz = kk > (PW+8)'(FRAC_BITS);
				pl_n[k].k = kk[PW-1:0];
				pl_n[k].acc = 32'h8000_0000;
			end else if (k < F_STG) begin
				if (pl_c[k].f[LOG_FRAC-(k-T_STG)]) begin
					prod = 64'(pl_c[k].acc) * 64'(EXP_TABS[32*(k-T_STG-1) +: 32]);
					pl_n[k].acc = prod[62:31];
				end
			end else begin
				sh = 6'(31 - FRAC_BITS) + 6'(pl_c[k].k);
				if (pl_c[k].ov) begin
					pl_n[k].res = pl_c[k].ovv;
				end else if (pl_c[k].kz) begin
					pl_n[k].res = '0;
				end else begin
					pl_n[k].res = BW'(pl_c[k].acc >> sh);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				pl_s[k+1] <= pl_n[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign pw = pl_s[N].res;
	assign ndl_out = pl_s[N].ndl;
	assign side_out = pl_s[N].side;

`ifndef ASSERT_OFF
	a_pw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pw <= ONE)
		else $error("power above one");
`endif

endmodule

// ----- rtl/core/bps_shade.sv -----
// color products, sum and saturation, ending in the output register
module bps_shade #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input bps_pkg::bps_cfg_t cfg,
	input logic [FRAC_BITS:0] pw,
	input logic [31-FRAC_BITS:0] ndl,
	input bps_pkg::bps_side_t side,
	output logic out_valid,
	output bps_pkg::bps_shade_t shade
);
	import bps_pkg::*;

	localparam int NW = 32 - FRAC_BITS;
	localparam int DPW = 2 * NW;
	localparam int SPW = NW + FRAC_BITS + 1;
	localparam int SUMW = ((DPW > SPW) ? DPW : SPW) + 1;

	logic [15:0] diff [3];
	logic [15:0] spec [3];
	logic [15:0] light [3];
	logic [31:0] dl [3];
	logic [31:0] sl [3];
	logic [SUMW-1:0] sum [3];

	logic [3:1] vld_s;
	logic [NW-1:0] cd_s1 [3];
	logic [NW-1:0] cs_s1 [3];
	logic [FRAC_BITS:0] pw_s1;
	logic [NW-1:0] ndl_s1;
	logic spec_s1;
	logic [DPW-1:0] pd_s2 [3];
	logic [SPW-1:0] ps_s2 [3];
	logic [15:0] out_s3 [3];

	always_comb begin
		diff[0] = cfg.diffuse_red;
		diff[1] = cfg.diffuse_green;
		diff[2] = cfg.diffuse_blue;
		spec[0] = cfg.specular_red;
		spec[1] = cfg.specular_green;
		spec[2] = cfg.specular_blue;
		light[0] = side.light_red;
		light[1] = side.light_green;
		light[2] = side.light_blue;
		for (int c = 0; c < 3; c++) begin
			dl[c] = 32'(diff[c]) * 32'(light[c]);
			sl[c] = 32'(spec[c]) * 32'(light[c]);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = SUMW'(pd_s2[c] >> FRAC_BITS) + SUMW'(ps_s2[c] >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[2:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				cd_s1[c] <= dl[c][31:FRAC_BITS];
				cs_s1[c] <= sl[c][31:FRAC_BITS];
				pd_s2[c] <= DPW'(cd_s1[c]) * DPW'(ndl_s1);
				ps_s2[c] <= spec_s1 ? SPW'(cs_s1[c]) * SPW'(pw_s1) : '0;
				out_s3[c] <= (|sum[c][SUMW-1:16]) ? 16'hFFFF : sum[c][15:0];
			end
			pw_s1 <= pw;
			ndl_s1 <= ndl;
			spec_s1 <= side.spec_on;
		end
	end

	assign out_valid = vld_s[3];
	assign shade.shade_red = out_s3[0];
	assign shade.shade_green = out_s3[1];
	assign shade.shade_blue = out_s3[2];

endmodule

// ----- rtl/core/blinn_phong_shader.sv -----
// top level of the blinn-phong shader: configuration registers and the pipeline
//
// sample channel: one shading sample per transaction (view, normal and light
// directions as signed q1.15, light color as unsigned q1.15), valid/ready.
// shade channel: one saturated rgb result per sample, unsigned q1.15, valid/ready,
// in the order the samples came in.
// configuration: cfg_we writes cfg_data[15:0] into the register at cfg_index
// (diffuse rgb, specular rgb, shininess q8.8); an index past shininess is dropped.
// write only while no sample is in flight.
// throughput: one sample per cycle, sustained while the shade channel is not stalled.
// pipeline from sample acceptance to shade valid: 2 dot-product stages, 17
// square-root stages, FRAC_BITS + 2 divide stages, 51 power stages (clamp,
// 24 squarings, scale, 24 table multiplies, final shift) and 3 color stages.
// the whole pipeline advances together; a stalled shade transaction holds every
// stage and drops sample_ready, and a bubble moves on whenever the output is free.
// reset clears all valid bits and loads material colors zero, shininess 1.0.
module blinn_phong_shader #(
	parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input bps_pkg::bps_sample_t sample,
	output logic shade_valid,
	input logic shade_ready,
	output bps_pkg::bps_shade_t shade,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import bps_pkg::*;

	localparam int NW = 32 - FRAC_BITS;

	bps_cfg_t cfg_q;
	logic advance;

	// front to square root
	logic fr_valid;
	logic [HH_W-1:0] fr_hh;
	logic [DN_W-1:0] fr_dpos;
	logic [NW-1:0] fr_ndl;
	bps_side_t fr_side;

	// square root to divide
	logic sq_valid;
	logic [LEN_W-1:0] sq_len;
	logic [DN_W-1:0] sq_dpos;
	logic [NW-1:0] sq_ndl;
	bps_side_t sq_side;

	// divide to power
	logic dv_valid;
	logic [FRAC_BITS:0] dv_quot;
	logic dv_sat;
	logic [NW-1:0] dv_ndl;
	bps_side_t dv_side;

	// power to color stages
	logic pw_valid;
	logic [FRAC_BITS:0] pw_val;
	logic [NW-1:0] pw_ndl;
	bps_side_t pw_side;

	// global advance: the output register is empty or being drained
	assign advance = !shade_valid || shade_ready;
	assign sample_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diffuse_red <= '0;
			cfg_q.diffuse_green <= '0;
			cfg_q.diffuse_blue <= '0;
			cfg_q.specular_red <= '0;
			cfg_q.specular_green <= '0;
			cfg_q.specular_blue <= '0;
			cfg_q.shininess <= SHININESS_RST;
		end else if (cfg_we) begin
			case (bps_reg_t'(cfg_index))
				REG_DIFFUSE_RED: cfg_q.diffuse_red <= cfg_data;
				REG_DIFFUSE_GREEN: cfg_q.diffuse_green <= cfg_data;
				REG_DIFFUSE_BLUE: cfg_q.diffuse_blue <= cfg_data;
				REG_SPECULAR_RED: cfg_q.specular_red <= cfg_data;
				REG_SPECULAR_GREEN: cfg_q.specular_green <= cfg_data;
				REG_SPECULAR_BLUE: cfg_q.specular_blue <= cfg_data;
				REG_SHININESS: cfg_q.shininess <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bps_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(sample_valid),
		.sample(sample),
		.out_valid(fr_valid),
		.hh(fr_hh),
		.dpos(fr_dpos),
		.ndl(fr_ndl),
		.side(fr_side)
	);

	bps_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(fr_valid),
		.hh(fr_hh),
		.dpos(fr_dpos),
		.ndl(fr_ndl),
		.side(fr_side),
		.out_valid(sq_valid),
		.len(sq_len),
		.dpos_out(sq_dpos),
		.ndl_out(sq_ndl),
		.side_out(sq_side)
	);

	bps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(sq_valid),
		.len(sq_len),
		.dpos(sq_dpos),
		.ndl(sq_ndl),
		.side(sq_side),
		.out_valid(dv_valid),
		.quot(dv_quot),
		.sat(dv_sat),
		.ndl_out(dv_ndl),
		.side_out(dv_side)
	);

	bps_pow #(.FRAC_BITS(FRAC_BITS)) u_pow (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(dv_valid),
		.quot(dv_quot),
		.sat(dv_sat),
		.expo(cfg_q.shininess),
		.ndl(dv_ndl),
		.side(dv_side),
		.out_valid(pw_valid),
		.pw(pw_val),
		.ndl_out(pw_ndl),
		.side_out(pw_side)
	);

	bps_shade #(.FRAC_BITS(FRAC_BITS)) u_shade (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.in_valid(pw_valid),
		.cfg(cfg_q),
		.pw(pw_val),
		.ndl(pw_ndl),
		.side(pw_side),
		.out_valid(shade_valid),
		.shade(shade)
	);

`ifndef ASSERT_OFF
	// a held result keeps the whole pipeline frozen, so the result is still there
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |=> shade_valid)
		else $error("result lost during stall");
`endif

endmodule

// ----- tb/blinn_phong_shader_test.sv -----
// self-checking testbench of the blinn-phong shader: directed and random samples
module blinn_phong_shader_test;
	import bps_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LOGF = LOG_FRAC;
	// settling wait after the last expected shade, longer than the pipeline depth
	localparam int DRAIN_CYCLES = FRAC + 75 + 40;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	bps_sample_t sample;
	logic shade_valid;
	logic shade_ready;
	bps_shade_t shade;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// testbench copy of the material registers
	bps_cfg_t material;
	// 2^(-2^-i) in q1.31, entry 0 is 0.5
	logic [63:0] exp_root [0:LOGF];
	bps_shade_t shade_queue [$];
	int errors = 0;
	int idle_cnt = 0;
	bit quiet;

	blinn_phong_shader dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.shade_valid(shade_valid),
		.shade_ready(shade_ready),
		.shade(shade),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// floor square root, bit-by-bit
	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// base in [0, 1.0] q1.15 raised to a q8.8 exponent, via log2 and the root table
	function automatic logic [63:0] power_q15(logic [63:0] base, logic [63:0] expo);
		logic [63:0] one;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] neglog;
		logic [63:0] t;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] acc;
		int p;
		one = 64'd1 << FRAC;
		if (expo == 0)
			return one;
		if (base == 0)
			return 0;
		if (base >= one)
			return one;
		p = 0;
		while (p < 62 && (base >> (p + 1)) != 0)
			p++;
		m = base << (31 - p);
		frac = 0;
		for (int i = 0; i < LOGF; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		neglog = (64'(FRAC - p) << LOGF) - frac;
		t = (neglog * expo) >> 8;
		k = t >> LOGF;
		if (k > FRAC)
			return 0;
		f = t & ((64'd1 << LOGF) - 1);
		acc = 64'd1 << 31;
		for (int i = 1; i <= LOGF; i++)
			if (f[LOGF - i])
				acc = (acc * exp_root[i]) >> 31;
		return (one * acc) >> (31 + k);
	endfunction

	// expected shade of one sample under the current material
	function automatic bps_shade_t predict_shade(bps_sample_t s);
		longint n [3];
		longint l [3];
		longint h [3];
		longint v [3];
		longint dnl;
		longint dnh;
		logic [63:0] hh;
		logic [63:0] ndl;
		logic [63:0] pw;
		logic [63:0] len;
		logic [63:0] cosv;
		logic [63:0] lt [3];
		logic [63:0] dif [3];
		logic [63:0] spc [3];
		logic [63:0] dterm;
		logic [63:0] sterm;
		logic [63:0] sum;
		logic [15:0] outc [3];
		bit spec_on;
		bps_shade_t r;
		n = '{longint'(s.normal_x), longint'(s.normal_y), longint'(s.normal_z)};
		l = '{longint'(s.light_dir_x), longint'(s.light_dir_y), longint'(s.light_dir_z)};
		v = '{longint'(s.view_dir_x), longint'(s.view_dir_y), longint'(s.view_dir_z)};
		lt = '{64'(s.light_red), 64'(s.light_green), 64'(s.light_blue)};
		dif = '{64'(material.diffuse_red), 64'(material.diffuse_green),
			64'(material.diffuse_blue)};
		spc = '{64'(material.specular_red), 64'(material.specular_green),
			64'(material.specular_blue)};
		dnl = 0;
		dnh = 0;
		hh = 0;
		pw = 0;
		spec_on = 0;
		for (int c = 0; c < 3; c++) begin
			h[c] = l[c] - v[c];
			dnl += n[c] * l[c];
			dnh += n[c] * h[c];
			hh += 64'(h[c] * h[c]);
		end
		ndl = (dnl > 0) ? (64'(dnl) >> FRAC) : 0;
		// a zero half vector switches the specular term off
		if (hh != 0) begin
			len = sqrt_floor(hh);
			cosv = (dnh > 0) ? 64'(dnh) / len : 0;
			if (cosv > (64'd1 << FRAC))
				cosv = 64'd1 << FRAC;
			pw = power_q15(cosv, 64'(material.shininess));
			spec_on = 1;
		end
		for (int c = 0; c < 3; c++) begin
			dterm = (((dif[c] * lt[c]) >> FRAC) * ndl) >> FRAC;
			sterm = spec_on ? ((((spc[c] * lt[c]) >> FRAC) * pw) >> FRAC) : 0;
			sum = dterm + sterm;
			outc[c] = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
		end
		r.shade_red = outc[0];
		r.shade_green = outc[1];
		r.shade_blue = outc[2];
		return r;
	endfunction

	function automatic bps_sample_t make_sample(logic [15:0] vx, logic [15:0] vy,
			logic [15:0] vz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
			logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
			logic [15:0] cr, logic [15:0] cg, logic [15:0] cb);
		bps_sample_t s;
		s = {vx, vy, vz, nx, ny, nz, lx, ly, lz, cr, cg, cb};
		return s;
	endfunction

	// small signed offset around a component, wrapped to 16 bits
	function automatic logic [15:0] near(logic [15:0] x, int spread);
		return x + 16'($urandom_range(0, 2 * spread) - spread);
	endfunction

	// random sample: mostly a roughly lit surface, sometimes pure noise
	function automatic bps_sample_t random_sample();
		bps_sample_t s;
		logic [15:0] nx, ny, nz;
		s = bps_sample_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(0, 9) < 7) begin
			nx = 16'($urandom_range(0, 23170)) - 16'd11585;
			ny = 16'($urandom_range(0, 23170)) - 16'd11585;
			nz = 16'd23170 + 16'($urandom_range(0, 9000));
			s.normal_x = nx;
			s.normal_y = ny;
			s.normal_z = nz;
			s.light_dir_x = near(nx, 6000);
			s.light_dir_y = near(ny, 6000);
			s.light_dir_z = near(nz, 3000);
			// ray points back toward the surface
			s.view_dir_x = near(-nx, 8000);
			s.view_dir_y = near(-ny, 8000);
			s.view_dir_z = near(-nz, 4000);
		end
		return s;
	endfunction

	// one sample transaction; valid stays high across back-to-back samples
	task automatic send_sample(bps_sample_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		shade_queue.push_back(predict_shade(s));
	endtask

	// wait until every expected shade has come, then let the pipeline settle
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (shade_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_SHININESS)
			case (bps_reg_t'(idx))
				REG_DIFFUSE_RED: material.diffuse_red = val;
				REG_DIFFUSE_GREEN: material.diffuse_green = val;
				REG_DIFFUSE_BLUE: material.diffuse_blue = val;
				REG_SPECULAR_RED: material.specular_red = val;
				REG_SPECULAR_GREEN: material.specular_green = val;
				REG_SPECULAR_BLUE: material.specular_blue = val;
				REG_SHININESS: material.shininess = val;
				default: ;
			endcase
	endtask

	task automatic set_material(logic [15:0] d, logic [15:0] sp, logic [15:0] sh);
		write_reg(REG_DIFFUSE_RED, d);
		write_reg(REG_DIFFUSE_GREEN, d ^ 16'h1234);
		write_reg(REG_DIFFUSE_BLUE, d);
		write_reg(REG_SPECULAR_RED, sp);
		write_reg(REG_SPECULAR_GREEN, sp);
		write_reg(REG_SPECULAR_BLUE, sp ^ 16'h0f0f);
		write_reg(REG_SHININESS, sh);
	endtask

	// reset values first, then field extremes and the named corner cases
	task automatic test_directed();
		// reset material: only black comes out
		send_sample(make_sample(16'h8000, 0, 0, 16'h7fff, 0, 0, 16'h7fff, 0, 0,
			16'hffff, 16'hffff, 16'hffff));
		drain();
		set_material(16'h7fff, 16'h7fff, 16'd256);
		// head-on light
		send_sample(make_sample(0, 0, 16'h8000, 0, 0, 16'h7fff, 0, 0, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000));
		// zero half vector: light equals ray direction
		send_sample(make_sample(0, 16'h4000, 0, 0, 16'h7fff, 0, 0, 16'h4000, 0,
			16'h7fff, 16'h7fff, 16'h7fff));
		// negative n.h: half vector points away from the normal
		send_sample(make_sample(0, 0, 16'h7fff, 0, 0, 16'h7fff, 16'h7fff, 0, 0,
			16'h7fff, 16'h1000, 16'hffff));
		// grazing light, n.l zero
		send_sample(make_sample(0, 0, 16'h8000, 0, 0, 16'h7fff, 16'h7fff, 0, 0,
			16'h4000, 16'h4000, 16'h4000));
		// all extremes negative and positive, non-unit vectors
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'hffff));
		send_sample(make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 0, 16'hffff));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(make_sample(16'h1000, 16'hf000, 16'hc000, 16'h2d41, 16'h2d41,
			16'h4000, 16'h4000, 16'h2000, 16'h6000, 16'h5555, 16'haaaa, 16'h0001));
		drain();
		// zero exponent: pow is one even for a zero base
		write_reg(REG_SHININESS, 16'd0);
		send_sample(make_sample(0, 0, 16'h7fff, 0, 0, 16'h7fff, 16'h7fff, 0, 0,
			16'h7fff, 16'h7fff, 16'h7fff));
		send_sample(make_sample(16'h2000, 0, 16'hc000, 0, 0, 16'h7fff, 16'h2000,
			0, 16'h7000, 16'h7fff, 16'h7fff, 16'h7fff));
		drain();
		// exponent 128.0; an index past the list must be dropped
		write_reg(REG_SHININESS, 16'd32768);
		write_reg(3'd7, 16'h0000);
		send_sample(make_sample(16'h2000, 0, 16'hc000, 0, 0, 16'h7fff, 16'h2000,
			0, 16'h7000, 16'h7fff, 16'h7fff, 16'h7fff));
		send_sample(make_sample(0, 0, 16'h7fff, 0, 0, 16'h7fff, 16'h7fff, 0, 0,
			16'h7fff, 16'h7fff, 16'h7fff));
		send_sample(make_sample(0, 0, 16'h8000, 0, 0, 16'h7fff, 0, 16'h0800,
			16'h7fe0, 16'hffff, 16'hffff, 16'hffff));
		drain();
	endtask

	// a burst of random samples under one material
	task automatic test_random(logic [15:0] d, logic [15:0] sp, logic [15:0] sh,
			int count, bit no_idle);
		set_material(d, sp, sh);
		quiet = no_idle;
		for (int i = 0; i < count; i++)
			send_sample(random_sample());
		drain();
		quiet = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		shade_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		material = '{default: 16'd0, shininess: SHININESS_RST};
		quiet = 0;
		exp_root[0] = 64'd1 << 30;
		for (int i = 1; i <= LOGF; i++)
			exp_root[i] = sqrt_floor(exp_root[i - 1] << 31);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(16'h7fff, 16'h7fff, 16'd2560, 120, 0);
		test_random(16'hffff, 16'hffff, 16'd32768, 100, 0);
		test_random(16'd0, 16'd0, 16'd0, 60, 1);
		test_random(16'h4000, 16'hffff, 16'd0, 80, 0);
		test_random(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32768)), 120, 0);
		test_random(16'h2000, 16'h6000, 16'd1, 120, 1);

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// shade side: random stalls, each result compared with the oldest expectation
	initial begin : shade_checker
		int stall;
		bps_shade_t want;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				shade_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			shade_ready <= 1'b1;
			do
				@(posedge clk);
			while (!shade_valid);
			if (shade_queue.size() == 0) begin
				errors++;
				$display("%0t unexpected shade transaction: expected none, actual %h",
					$time, shade);
			end else begin
				want = shade_queue.pop_front();
				check_field("shade_red", want.shade_red, shade.shade_red);
				check_field("shade_green", want.shade_green, shade.shade_green);
				check_field("shade_blue", want.shade_blue, shade.shade_blue);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (shade_valid && shade_ready)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
